### src/deq_pkg.sv
// package: shared constants, codes and types for the double-ended queue
package deq_pkg;

	localparam int DEPTH_DEF     = 64;
	localparam int WORD_BITS_DEF = 32;
	localparam int MODE_W        = 3;
	localparam int ITEM_W        = 32;
	localparam int STATUS_W      = 2;
	localparam int OCC_W         = 7;

	typedef enum logic [MODE_W-1:0] {
		MODE_PUSH_FRONT = 3'd0,
		MODE_PUSH_REAR  = 3'd1,
		MODE_POP_FRONT  = 3'd2,
		MODE_POP_REAR   = 3'd3,
		MODE_COUNT      = 3'd4,
		MODE_DUMP       = 3'd5
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	// what every cell of the chain does when clocked
	typedef enum logic [2:0] {
		CMD_HOLD,
		CMD_PUSH_FRONT,
		CMD_PUSH_REAR,
		CMD_POP_FRONT,
		CMD_ROTATE
	} cell_cmd_t;

	typedef enum logic {
		S_IDLE,
		S_DUMP
	} ctrl_state_t;

endpackage

### src/deq_cell.sv
// one storage cell of the queue chain
module deq_cell import deq_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int CNT_W     = 7,
	parameter int IDX       = 0
) (
	input  logic                 clk,
	input  cell_cmd_t            cmd,
	input  logic [CNT_W-1:0]     cnt,
	input  logic [CNT_W-1:0]     last_idx,
	input  logic [WORD_BITS-1:0] load_word,
	input  logic [WORD_BITS-1:0] left_word,
	input  logic [WORD_BITS-1:0] right_word,
	input  logic [WORD_BITS-1:0] wrap_word,
	output logic [WORD_BITS-1:0] data,
	output logic [WORD_BITS-1:0] tap
);

	localparam logic [CNT_W-1:0] MyIdx = CNT_W'(IDX);

	logic [WORD_BITS-1:0] data_q;
	logic [WORD_BITS-1:0] data_d;
	logic                 is_rear;

	assign is_rear = (last_idx == MyIdx);

	always_comb begin
		data_d = data_q;
		case (cmd)
			CMD_PUSH_FRONT: data_d = (IDX == 0) ? load_word : left_word;
			CMD_PUSH_REAR:  if (cnt == MyIdx) data_d = load_word;
			CMD_POP_FRONT:  data_d = right_word;
			// front word wraps around to the rear slot
			CMD_ROTATE:     data_d = is_rear ? wrap_word : right_word;
			default:        data_d = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;
	assign tap  = is_rear ? data_q : '0;

endmodule

### src/double_ended_queue_top.sv
// top level: double-ended queue built as a chain of shifting cells
//
// usage
//   input channel  (in_valid / in_stall): one word of mode and value
//   output channel (out_valid / out_stall): status, item, occupancy, last
//   the queue is kept front to rear in a row of DEPTH cells, front in cell 0
//   push front and pop front shift the whole row by one cell; push rear
//   writes the cell at the fill count; pop rear reads the rear cell
// results and throughput
//   push, pop and count: result registered at acceptance,
//   one word per cycle sustained while out_stall stays low
//   dump of n entries: n results, one per cycle while out_stall is low; the row
//   rotates by one cell per result, so after the dump the contents are back in
//   place; no new word is taken until the dump ends
// reset
//   arst_n clears fill count, remaining-dump count, control state and output
//   valid; cell contents are left as they are and are never read before being written
// backpressure
//   while out_stall holds a pending result, the result holds and in_stall
//   rises; a dump pauses its rotation until the result is taken
module double_ended_queue_top import deq_pkg::*; #(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [MODE_W-1:0]          mode,
	input  logic signed [ITEM_W-1:0]   value,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [STATUS_W-1:0]        status,
	output logic signed [ITEM_W-1:0]   item,
	output logic [OCC_W-1:0]           occupancy,
	output logic                       last
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W-1:0] FullCnt = CNT_W'(DEPTH);
	localparam logic [CNT_W-1:0] OneCnt  = CNT_W'(1);

	// stored word read back as a 32-bit item, sign-extended or cut
	function automatic logic [ITEM_W-1:0] to_item(input logic [WORD_BITS-1:0] w);
		logic signed [WORD_BITS-1:0] sw;
		sw = signed'(w);
		return ITEM_W'(sw);
	endfunction

	// control state
	ctrl_state_t      state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [CNT_W-1:0] left_q, left_d;

	// output register
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [ITEM_W-1:0]   item_q;
	logic [OCC_W-1:0]    occ_q;
	logic                last_q;

	// step results
	logic                load_out;
	status_t             o_status;
	logic [ITEM_W-1:0]   o_item;
	logic                o_last;
	cell_cmd_t           cmd;

	logic                 slot_free;
	logic                 acc;
	logic [CNT_W-1:0]     last_idx;
	logic [WORD_BITS-1:0] push_word;
	logic [WORD_BITS-1:0] cell_d   [DEPTH];
	logic [WORD_BITS-1:0] cell_tap [DEPTH];
	logic [WORD_BITS-1:0] rear_word;

	assign push_word = WORD_BITS'(value);
	assign last_idx  = cnt_q - OneCnt;

	// cell row; front word is broadcast back for dump rotation
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		deq_cell #(
			.WORD_BITS (WORD_BITS),
			.CNT_W     (CNT_W),
			.IDX       (i)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.cnt        (cnt_q),
			.last_idx   (last_idx),
			.load_word  (push_word),
			.left_word  (cell_d[(i == 0) ? 0 : i - 1]),
			.right_word (cell_d[(i == DEPTH - 1) ? i : i + 1]),
			.wrap_word  (cell_d[0]),
			.data       (cell_d[i]),
			.tap        (cell_tap[i])
		);
	end

	// only the rear cell drives its tap, so an or-merge picks it
	always_comb begin
		rear_word = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rear_word = rear_word | cell_tap[i];
		end
	end

	// handshake: output register frees when empty or being taken
	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = (state_q == S_DUMP) || !slot_free;
	assign acc       = in_valid && !in_stall;

	// next state and step outputs
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		left_d   = left_q;
		load_out = 1'b0;
		o_status = STAT_OK;
		o_item   = '0;
		o_last   = 1'b1;
		cmd      = CMD_HOLD;
		if (state_q == S_DUMP) begin
			if (slot_free) begin
				load_out = 1'b1;
				o_item   = to_item(cell_d[0]);
				o_last   = (left_q == OneCnt);
				cmd      = CMD_ROTATE;
				left_d   = left_q - OneCnt;
				if (left_q == OneCnt) begin
					state_d = S_IDLE;
				end
			end
		end else if (acc) begin
			load_out = 1'b1;
			case (mode)
				MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
					if (cnt_q == FullCnt) begin
						o_status = STAT_FULL;
					end else begin
						cmd   = (mode == MODE_PUSH_FRONT) ? CMD_PUSH_FRONT : CMD_PUSH_REAR;
						cnt_d = cnt_q + OneCnt;
					end
				end
				MODE_POP_FRONT: begin
					if (cnt_q == '0) begin
						o_status = STAT_EMPTY;
					end else begin
						o_item = to_item(cell_d[0]);
						cmd    = CMD_POP_FRONT;
						cnt_d  = cnt_q - OneCnt;
					end
				end
				MODE_POP_REAR: begin
					if (cnt_q == '0) begin
						o_status = STAT_EMPTY;
					end else begin
						o_item = to_item(rear_word);
						cnt_d  = cnt_q - OneCnt;
					end
				end
				MODE_DUMP: begin
					if (cnt_q == '0) begin
						o_status = STAT_EMPTY;
					end else begin
						// first entry goes out now, the rest stream from the dump state
						o_item = to_item(cell_d[0]);
						o_last = (cnt_q == OneCnt);
						cmd    = CMD_ROTATE;
						left_d = cnt_q - OneCnt;
						if (cnt_q != OneCnt) begin
							state_d = S_DUMP;
						end
					end
				end
				default: begin
					// count and unused modes report occupancy only
					o_status = STAT_OK;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			left_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			left_q      <= left_d;
			out_valid_q <= load_out || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q <= o_status;
			item_q   <= o_item;
			occ_q    <= OCC_W'(cnt_d);
			last_q   <= o_last;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign item      = signed'(item_q);
	assign occupancy = occ_q;
	assign last      = last_q;

endmodule

### verif/tb.sv
// testbench for double_ended_queue_top: shadow deque prediction with random pacing
`timescale 1ns / 1ps

module tb;
	import deq_pkg::*;

	localparam int DEPTH         = DEPTH_DEF;
	localparam int IDLE_LIMIT    = 3000;  // cycles with no word moving on either side
	localparam int LONG_HOLD     = 150;   // receiver hold-off for the backpressure test
	localparam int TRAIL_CYCLES  = 10;    // settle time after the last result
	localparam int RANDOM_WORDS  = 170;

	// modes the block does not define; they must be ignored
	localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

	localparam logic signed [ITEM_W-1:0] WORD_MAX = 32'sh7fffffff;
	localparam logic signed [ITEM_W-1:0] WORD_MIN = 32'sh80000000;

	// one result word as the block should present it
	typedef struct {
		status_t                   status;
		logic signed [ITEM_W-1:0]  item;
		logic [OCC_W-1:0]          occupancy;
		logic                      last;
	} deq_result_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic [MODE_W-1:0]         mode = '0;
	logic signed [ITEM_W-1:0]  value = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic [STATUS_W-1:0]       status;
	logic signed [ITEM_W-1:0]  item;
	logic [OCC_W-1:0]          occupancy;
	logic                      last;

	// shadow copy of the queue contents, front at index 0
	logic signed [ITEM_W-1:0]  shadow_deque[$];
	// results still owed by the block, oldest first
	deq_result_t               due_results[$];

	int mismatches = 0;
	int burst_left = 0;
	int hold_off_len = 0;  // set by a test to make the receiver hold off
	int idle_cycles = 0;

	double_ended_queue_top dut (
		.clk,
		.arst_n,
		.in_valid,
		.in_stall,
		.mode,
		.value,
		.out_valid,
		.out_stall,
		.status,
		.item,
		.occupancy,
		.last
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// --------------------------------------------------------------------
	// prediction: apply one accepted word to the shadow deque and queue up
	// every result it should cause
	// --------------------------------------------------------------------
	task automatic apply_to_shadow(input logic [MODE_W-1:0] m,
			input logic signed [ITEM_W-1:0] v);
		deq_result_t               r;
		logic signed [ITEM_W-1:0]  stored;
		int unsigned               sh;
		// stored words keep WORD_BITS and read back sign-extended
		sh = (WORD_BITS_DEF < ITEM_W) ? ITEM_W - WORD_BITS_DEF : 0;
		stored = (v <<< sh) >>> sh;
		r.status = STAT_OK;
		r.item = '0;
		r.last = 1'b1;
		case (m)
		MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
			if (shadow_deque.size() >= DEPTH)
				r.status = STAT_FULL;
			else if (m == MODE_PUSH_FRONT)
				shadow_deque.push_front(stored);
			else
				shadow_deque.push_back(stored);
		end
		MODE_POP_FRONT: begin
			if (shadow_deque.size() == 0)
				r.status = STAT_EMPTY;
			else
				r.item = shadow_deque.pop_front();
		end
		MODE_POP_REAR: begin
			if (shadow_deque.size() == 0)
				r.status = STAT_EMPTY;
			else
				r.item = shadow_deque.pop_back();
		end
		MODE_DUMP: begin
			if (shadow_deque.size() == 0) begin
				r.status = STAT_EMPTY;
			end else begin
				// one result per entry, front to rear, last one marked
				for (int k = 0; k < shadow_deque.size(); k++) begin
					r.item = shadow_deque[k];
					r.occupancy = OCC_W'(shadow_deque.size());
					r.last = (k == shadow_deque.size() - 1);
					due_results.push_back(r);
				end
				return;
			end
		end
		default: ;  // count and the spare modes change nothing
		endcase
		r.occupancy = OCC_W'(shadow_deque.size());
		due_results.push_back(r);
	endtask

	// --------------------------------------------------------------------
	// sender side
	// --------------------------------------------------------------------

	// present one word and hold it until the block takes it; valid stays
	// high afterwards so back-to-back words need no extra step
	task automatic offer_word(input logic [MODE_W-1:0] m,
			input logic signed [ITEM_W-1:0] v);
		in_valid <= 1'b1;
		mode <= m;
		value <= v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		apply_to_shadow(m, v);
	endtask

	// burst pacing: after a burst of random length, a random gap
	task automatic sender_gap;
		int gap;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		// now and then a long burst so there are stretches with no idling
		burst_left = ($urandom_range(5) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
		gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop offering and wait for every owed result
	task automatic wait_for_drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (due_results.size() != 0)
			@(posedge clk);
	endtask

	// mostly random words, with the extremes mixed in
	function automatic logic signed [ITEM_W-1:0] pick_value();
		case ($urandom_range(15))
		0: return WORD_MAX;
		1: return WORD_MIN;
		2: return '1;
		3: return '0;
		default: return $urandom;
		endcase
	endfunction

	// --------------------------------------------------------------------
	// receiver side: stall pattern of its own, plus an on-demand hold-off
	// --------------------------------------------------------------------
	initial begin : receiver_stall
		int stall_pct;
		int pattern_left;
		int held_for;
		stall_pct = 0;
		pattern_left = 0;
		held_for = 0;
		forever begin
			@(posedge clk);
			if (hold_off_len > 0) begin
				held_for = hold_off_len;
				hold_off_len = 0;
			end
			if (held_for > 0) begin
				held_for--;
				out_stall <= 1'b1;
			end else begin
				// switch between no stall, light stall and heavy stall
				if (pattern_left == 0) begin
					pattern_left = $urandom_range(10, 60);
					case ($urandom_range(2))
					0: stall_pct = 0;
					1: stall_pct = 25;
					default: stall_pct = 70;
					endcase
				end
				pattern_left--;
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// --------------------------------------------------------------------
	// result checking: every accepted result against the oldest owed one
	// --------------------------------------------------------------------
	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		deq_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (due_results.size() == 0) begin
				$display("%0t: result with none owed, expected nothing, actual status %0h item %0h",
					$time, status, item);
				mismatches++;
			end else begin
				want = due_results.pop_front();
				check_field("status", 64'(want.status), 64'(status));
				check_field("item", 64'(unsigned'(want.item)), 64'(unsigned'(item)));
				check_field("occupancy", 64'(want.occupancy), 64'(occupancy));
				check_field("last", 64'(want.last), 64'(last));
			end
		end
	end

	// watchdog: nothing moving on either side for too long ends the run
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
			$display("double_ended_queue_top verification failed");
			$finish;
		end
	end

	// --------------------------------------------------------------------
	// tests
	// --------------------------------------------------------------------

	// empty-queue cases, spare modes, extreme words, every mode once or more
	task automatic test_corner_cases;
		// on an empty queue: pops and dump report empty, count reports zero
		offer_word(MODE_POP_FRONT, '1);
		sender_gap;
		offer_word(MODE_POP_REAR, WORD_MIN);
		sender_gap;
		offer_word(MODE_DUMP, WORD_MAX);
		sender_gap;
		offer_word(MODE_COUNT, '1);
		sender_gap;
		// undefined modes are ignored whatever the value
		offer_word(MODE_SPARE_6, '1);
		sender_gap;
		offer_word(MODE_SPARE_7, WORD_MAX);
		sender_gap;
		// extremes pushed at both ends
		offer_word(MODE_PUSH_FRONT, WORD_MAX);
		sender_gap;
		offer_word(MODE_PUSH_REAR, WORD_MIN);
		sender_gap;
		offer_word(MODE_PUSH_FRONT, '1);
		sender_gap;
		offer_word(MODE_PUSH_REAR, '0);
		sender_gap;
		offer_word(MODE_PUSH_FRONT, 32'sd1);
		sender_gap;
		offer_word(MODE_COUNT, '0);
		sender_gap;
		offer_word(MODE_DUMP, '0);
		sender_gap;
		offer_word(MODE_SPARE_6, '0);
		sender_gap;
		// drain from both ends; pop values are ignored
		offer_word(MODE_POP_FRONT, WORD_MAX);
		sender_gap;
		offer_word(MODE_POP_REAR, '1);
		sender_gap;
		offer_word(MODE_POP_FRONT, '0);
		sender_gap;
		offer_word(MODE_POP_REAR, WORD_MIN);
		sender_gap;
		offer_word(MODE_POP_FRONT, '1);
		sender_gap;
		// emptied again
		offer_word(MODE_POP_REAR, '0);
		sender_gap;
		offer_word(MODE_DUMP, '1);
		sender_gap;
	endtask

	// fill to capacity, refuse pushes at both ends, dump a full queue,
	// then drain it from random ends
	task automatic test_fill_and_drain;
		while (shadow_deque.size() < DEPTH) begin
			offer_word($urandom_range(1) ? MODE_PUSH_FRONT : MODE_PUSH_REAR, pick_value());
			sender_gap;
		end
		offer_word(MODE_PUSH_FRONT, pick_value());
		sender_gap;
		offer_word(MODE_PUSH_REAR, pick_value());
		sender_gap;
		offer_word(MODE_COUNT, pick_value());
		sender_gap;
		offer_word(MODE_DUMP, pick_value());
		sender_gap;
		while (shadow_deque.size() > 0) begin
			offer_word($urandom_range(1) ? MODE_POP_FRONT : MODE_POP_REAR, pick_value());
			sender_gap;
		end
		offer_word(MODE_POP_FRONT, pick_value());
		sender_gap;
		offer_word(MODE_COUNT, pick_value());
		sender_gap;
	endtask

	// receiver holds off for a long stretch while words keep coming with
	// no gaps, so the block backs up and stalls its input; then the sender
	// pauses until every result is in
	task automatic test_backpressure;
		hold_off_len = LONG_HOLD;
		for (int n = 0; n < 30; n++) begin
			if (n == 12)
				offer_word(MODE_DUMP, pick_value());
			else if (n % 5 == 4)
				offer_word(MODE_POP_REAR, pick_value());
			else
				offer_word($urandom_range(1) ? MODE_PUSH_FRONT : MODE_PUSH_REAR,
					pick_value());
		end
		wait_for_drain;
	endtask

	// weighted random modes; the push/pop balance flips every few dozen
	// words so the occupancy sweeps up and down
	task automatic test_random_mix;
		int push_pct;
		int pick;
		logic [MODE_W-1:0] m;
		push_pct = 60;
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n % 40 == 39)
				push_pct = (push_pct == 60) ? 30 : 60;
			pick = $urandom_range(99);
			if (pick < push_pct)
				m = $urandom_range(1) ? MODE_PUSH_FRONT : MODE_PUSH_REAR;
			else if (pick < 86)
				m = $urandom_range(1) ? MODE_POP_FRONT : MODE_POP_REAR;
			else if (pick < 92)
				m = MODE_COUNT;
			else if (pick < 98)
				m = MODE_DUMP;
			else
				m = $urandom_range(1) ? MODE_SPARE_6 : MODE_SPARE_7;
			offer_word(m, pick_value());
			sender_gap;
		end
	endtask

	// --------------------------------------------------------------------
	// sequence
	// --------------------------------------------------------------------
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corner_cases;
		wait_for_drain;
		test_fill_and_drain;
		wait_for_drain;
		test_backpressure;
		test_random_mix;
		wait_for_drain;
		repeat (TRAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("double_ended_queue_top verification clean");
		else
			$display("double_ended_queue_top verification failed");
		$finish;
	end

endmodule

### sim.f
src/deq_pkg.sv
src/deq_cell.sv
src/double_ended_queue_top.sv
verif/tb.sv
